@@ rtl/core/mmta_pkg.sv @@
// Shared types and constants for the matrix multiply / transpose / accumulate block.
// Holds the sequencer state enum, operation and register codes, and the MAC control word.
// No dependencies.
package mmta_pkg;

  // Fixed field widths
  localparam int VALUE_W    = 32;  // width of value and read_value words
  localparam int CNT_W      = 5;   // width of the count registers
  localparam int ADDR_W     = 5;   // APB byte address width
  localparam int ACC_W      = 64;  // accumulator width
  localparam int PROD_SHIFT = 16;  // Q16.16 product alignment

  // Operation codes of an input word
  typedef enum logic [2:0] {
    OP_LOAD_A   = 3'd0,
    OP_LOAD_B   = 3'd1,
    OP_LOAD_C   = 3'd2,
    OP_MULTIPLY = 3'd3,
    OP_READ_C   = 3'd4
  } op_e;

  // Register indexes (byte address / 4)
  typedef enum logic [2:0] {
    REG_TRANSPOSE_A  = 3'd0,
    REG_TRANSPOSE_B  = 3'd1,
    REG_TRANSPOSE_C  = 3'd2,
    REG_ACCUMULATE   = 3'd3,
    REG_ROW_COUNT    = 3'd4,
    REG_LINK_COUNT   = 3'd5,
    REG_COLUMN_COUNT = 3'd6
  } reg_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RADDR,
    ST_READ,
    ST_CRD,
    ST_CINIT,
    ST_ABRD,
    ST_MUL,
    ST_ACC,
    ST_WR,
    ST_DONE
  } state_e;

  // Control word from the sequencer to the MAC unit
  typedef struct packed {
    logic init;   // load accumulator with start value
    logic use_c;  // start value is the stored C element, else zero
    logic mul;    // register the product of the A and B words
    logic acc;    // add the aligned product into the accumulator
  } mac_ctrl_t;

endpackage

@@ rtl/core/matrix_multiply_transpose_accumulate_top.sv @@
// Matrix multiply with transpose flags and accumulation, signed Q16.16 fixed point.
// Top level: APB register file, sequencer, A/B/C stores, output register.
// Depends on mmta_pkg, mmta_ram, mmta_mac.

// Loads of A, B and C are taken back to back. A read of C registers its address,
// reads the C store and then waits for the output register. A multiply runs on
// one shared MAC unit under a sequencer for R rows, N columns and L links (counts
// above MAX_DIM act as MAX_DIM); each link step has a state for the store read,
// one for the multiplier and one for the accumulator, and each element adds a C
// read, an initial load and a write back. A multiply with a zero row or column
// count goes straight to its done result. Only one word is in work at a time:
// in_stall_o is high from the acceptance of a read or multiply until its result
// enters the output register, which holds it until taken. Stores are not cleared
// at reset; entries must be loaded before they are used.
module matrix_multiply_transpose_accumulate_top #(
  parameter int MAX_DIM    = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // APB configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mmta_pkg::ADDR_W-1:0]         paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  // Input words
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [2:0]                          operation_i,
  input  logic [3:0]                          row_i,
  input  logic [3:0]                          col_i,
  input  logic signed [mmta_pkg::VALUE_W-1:0] value_i,
  // Result words
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [mmta_pkg::VALUE_W-1:0] read_value_o,
  output logic                                done_res_o,
  output logic                                saturated_o
);

  localparam int VW   = mmta_pkg::VALUE_W;
  localparam int CW   = mmta_pkg::CNT_W;
  localparam int IW   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int NW   = (IW + 1 > CW) ? IW + 1 : CW;
  localparam int MAW  = 2 * IW;

  // Configuration registers
  logic          transpose_a_q, transpose_b_q, transpose_c_q, accumulate_q;
  logic [CW-1:0] row_count_q, link_count_q, column_count_q;
  logic          cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      transpose_a_q  <= 1'b0;
      transpose_b_q  <= 1'b0;
      transpose_c_q  <= 1'b0;
      accumulate_q   <= 1'b0;
      row_count_q    <= CW'(1);
      link_count_q   <= CW'(1);
      column_count_q <= CW'(1);
    end else if (cfg_we) begin
      case (paddr[4:2])
        mmta_pkg::REG_TRANSPOSE_A:  transpose_a_q  <= pwdata[0];
        mmta_pkg::REG_TRANSPOSE_B:  transpose_b_q  <= pwdata[0];
        mmta_pkg::REG_TRANSPOSE_C:  transpose_c_q  <= pwdata[0];
        mmta_pkg::REG_ACCUMULATE:   accumulate_q   <= pwdata[0];
        mmta_pkg::REG_ROW_COUNT:    row_count_q    <= pwdata[CW-1:0];
        mmta_pkg::REG_LINK_COUNT:   link_count_q   <= pwdata[CW-1:0];
        mmta_pkg::REG_COLUMN_COUNT: column_count_q <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (paddr[4:2])
      mmta_pkg::REG_TRANSPOSE_A:  prdata = 32'(transpose_a_q);
      mmta_pkg::REG_TRANSPOSE_B:  prdata = 32'(transpose_b_q);
      mmta_pkg::REG_TRANSPOSE_C:  prdata = 32'(transpose_c_q);
      mmta_pkg::REG_ACCUMULATE:   prdata = 32'(accumulate_q);
      mmta_pkg::REG_ROW_COUNT:    prdata = 32'(row_count_q);
      mmta_pkg::REG_LINK_COUNT:   prdata = 32'(link_count_q);
      mmta_pkg::REG_COLUMN_COUNT: prdata = 32'(column_count_q);
      default:                    prdata = '0;
    endcase
  end

  // Effective counts, clamped to MAX_DIM
  logic [NW-1:0] nr, nl, nc;
  assign nr = (NW'(row_count_q) > NW'(MAX_DIM)) ? NW'(MAX_DIM) : NW'(row_count_q);
  assign nl = (NW'(link_count_q) > NW'(MAX_DIM)) ? NW'(MAX_DIM) : NW'(link_count_q);
  assign nc = (NW'(column_count_q) > NW'(MAX_DIM)) ? NW'(MAX_DIM) : NW'(column_count_q);

  // Input decode
  logic          in_fire;
  logic [NW-1:0] row_ext, col_ext;
  logic          coord_ok;
  logic [MAW-1:0] in_addr;
  logic [DATA_WIDTH-1:0] in_data;

  assign in_fire  = in_valid_i & ~in_stall_o;
  assign row_ext  = NW'(row_i);
  assign col_ext  = NW'(col_i);
  assign coord_ok = (row_ext < NW'(MAX_DIM)) && (col_ext < NW'(MAX_DIM));
  assign in_addr  = {row_ext[IW-1:0], col_ext[IW-1:0]};
  assign in_data  = value_i[DATA_WIDTH-1:0];

  // Sequencer registers
  mmta_pkg::state_e state_q, state_d;
  logic [IW-1:0]    i_q, i_d, j_q, j_d, k_q, k_d;
  logic [MAW-1:0]   addr_q;
  logic             ok_q;
  logic             sat_q;

  logic i_last, j_last, k_last;
  assign i_last = (NW'(i_q) + NW'(1)) == nr;
  assign j_last = (NW'(j_q) + NW'(1)) == nc;
  assign k_last = (NW'(k_q) + NW'(1)) == nl;

  // Store addresses
  logic [MAW-1:0] a_raddr, b_raddr, c_elem, c_raddr, c_waddr;
  assign a_raddr = transpose_a_q ? {k_q, i_q} : {i_q, k_q};
  assign b_raddr = transpose_b_q ? {j_q, k_q} : {k_q, j_q};
  assign c_elem  = transpose_c_q ? {j_q, i_q} : {i_q, j_q};

  // Output register handshake
  logic out_valid_q;
  logic out_free;
  assign out_free = ~out_valid_q | ~out_stall_i;

  // Sequencer controls
  mmta_pkg::mac_ctrl_t mac_ctrl;
  logic mac_sat;
  logic [DATA_WIDTH-1:0] mac_res;
  logic c_wr_mul;
  logic sat_clr, sat_set;
  logic out_load_read, out_load_done;
  logic in_read;

  // Next state and controls
  always_comb begin
    state_d       = state_q;
    i_d           = i_q;
    j_d           = j_q;
    k_d           = k_q;
    mac_ctrl      = '0;
    mac_ctrl.use_c = accumulate_q;
    c_wr_mul      = 1'b0;
    sat_clr       = 1'b0;
    sat_set       = 1'b0;
    out_load_read = 1'b0;
    out_load_done = 1'b0;
    in_read       = 1'b0;
    case (state_q)
      mmta_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (operation_i)
            mmta_pkg::OP_READ_C: begin
              in_read = 1'b1;
              state_d = mmta_pkg::ST_RADDR;
            end
            mmta_pkg::OP_MULTIPLY: begin
              sat_clr = 1'b1;
              i_d     = '0;
              j_d     = '0;
              if (nr == '0 || nc == '0) begin
                state_d = mmta_pkg::ST_DONE;
              end else begin
                state_d = mmta_pkg::ST_CRD;
              end
            end
            default: ;
          endcase
        end
      end
      mmta_pkg::ST_RADDR: state_d = mmta_pkg::ST_READ;
      mmta_pkg::ST_READ: begin
        if (out_free) begin
          out_load_read = 1'b1;
          state_d       = mmta_pkg::ST_IDLE;
        end
      end
      mmta_pkg::ST_CRD: state_d = mmta_pkg::ST_CINIT;
      mmta_pkg::ST_CINIT: begin
        mac_ctrl.init = 1'b1;
        k_d           = '0;
        state_d       = (nl == '0) ? mmta_pkg::ST_WR : mmta_pkg::ST_ABRD;
      end
      mmta_pkg::ST_ABRD: state_d = mmta_pkg::ST_MUL;
      mmta_pkg::ST_MUL: begin
        mac_ctrl.mul = 1'b1;
        state_d      = mmta_pkg::ST_ACC;
      end
      mmta_pkg::ST_ACC: begin
        mac_ctrl.acc = 1'b1;
        if (k_last) begin
          state_d = mmta_pkg::ST_WR;
        end else begin
          k_d     = k_q + IW'(1);
          state_d = mmta_pkg::ST_ABRD;
        end
      end
      mmta_pkg::ST_WR: begin
        c_wr_mul = 1'b1;
        sat_set  = mac_sat;
        state_d  = mmta_pkg::ST_CRD;
        if (j_last) begin
          j_d = '0;
          if (i_last) begin
            state_d = mmta_pkg::ST_DONE;
          end else begin
            i_d = i_q + IW'(1);
          end
        end else begin
          j_d = j_q + IW'(1);
        end
      end
      mmta_pkg::ST_DONE: begin
        if (out_free) begin
          out_load_done = 1'b1;
          state_d       = mmta_pkg::ST_IDLE;
        end
      end
      default: state_d = mmta_pkg::ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != mmta_pkg::ST_IDLE);

  // State and loop counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mmta_pkg::ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      sat_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      if (sat_clr) begin
        sat_q <= 1'b0;
      end else if (sat_set) begin
        sat_q <= 1'b1;
      end
    end
  end

  // Read-back coordinates
  always_ff @(posedge clk_i) begin
    if (in_read) begin
      addr_q <= in_addr;
      ok_q   <= coord_ok;
    end
  end

  // Store write enables
  logic a_we, b_we, c_we;
  logic [DATA_WIDTH-1:0] c_wdata;
  assign a_we = in_fire && coord_ok && (operation_i == mmta_pkg::OP_LOAD_A);
  assign b_we = in_fire && coord_ok && (operation_i == mmta_pkg::OP_LOAD_B);
  assign c_we = c_wr_mul ||
                (in_fire && coord_ok && (operation_i == mmta_pkg::OP_LOAD_C));
  assign c_waddr = c_wr_mul ? c_elem : in_addr;
  assign c_wdata = c_wr_mul ? mac_res : in_data;

  // C read port: element under work during a multiply, else the read-back address
  assign c_raddr = (state_q == mmta_pkg::ST_RADDR || state_q == mmta_pkg::ST_READ ||
                    state_q == mmta_pkg::ST_IDLE) ? addr_q : c_elem;

  logic [DATA_WIDTH-1:0] a_rdata, b_rdata, c_rdata;

  mmta_ram #(.AW(MAW), .DW(DATA_WIDTH)) u_store_a (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (in_addr),
    .wdata_i (in_data),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  mmta_ram #(.AW(MAW), .DW(DATA_WIDTH)) u_store_b (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (in_addr),
    .wdata_i (in_data),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  mmta_ram #(.AW(MAW), .DW(DATA_WIDTH)) u_store_c (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  // Shared MAC unit
  mmta_mac #(.DATA_WIDTH(DATA_WIDTH)) u_mac (
    .clk_i    (clk_i),
    .ctrl_i   (mac_ctrl),
    .a_i      (a_rdata),
    .b_i      (b_rdata),
    .c_i      (c_rdata),
    .result_o (mac_res),
    .sat_o    (mac_sat)
  );

  // Output register
  logic signed [DATA_WIDTH-1:0] c_rdata_s;
  logic signed [VW-1:0]         read_value_q;
  logic                         done_res_q, saturated_q;

  assign c_rdata_s = c_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load_read || out_load_done) begin
      out_valid_q <= 1'b1;
    end else if (~out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load_read) begin
      read_value_q <= ok_q ? VW'(c_rdata_s) : '0;
      done_res_q   <= 1'b0;
      saturated_q  <= sat_q;
    end else if (out_load_done) begin
      read_value_q <= '0;
      done_res_q   <= 1'b1;
      saturated_q  <= sat_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;
  assign done_res_o   = done_res_q;
  assign saturated_o  = saturated_q;

endmodule

@@ rtl/core/mmta_ram.sv @@
// Simple dual-port store: one write port, one read port with registered read data.
// Used for the A, B and C element stores. No dependencies.
module mmta_ram #(
  parameter int AW = 8,
  parameter int DW = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [1<<AW];
  logic [DW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/mmta_mac.sv @@
// Shared multiply-accumulate unit: registered signed product, Q16.16 alignment,
// 64-bit accumulator and saturation to DATA_WIDTH bits. Depends on mmta_pkg.
module mmta_mac #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  mmta_pkg::mac_ctrl_t          ctrl_i,
  input  logic signed [DATA_WIDTH-1:0] a_i,
  input  logic signed [DATA_WIDTH-1:0] b_i,
  input  logic signed [DATA_WIDTH-1:0] c_i,
  output logic signed [DATA_WIDTH-1:0] result_o,
  output logic                         sat_o
);

  localparam int AW = mmta_pkg::ACC_W;
  localparam int PW = 2 * DATA_WIDTH;
  localparam int SW = PW - mmta_pkg::PROD_SHIFT;
  localparam logic signed [AW-1:0] HI = (AW'(1) <<< (DATA_WIDTH - 1)) - AW'(1);
  localparam logic signed [AW-1:0] LO = -HI - AW'(1);

  logic signed [PW-1:0] prod_q;
  logic signed [SW-1:0] prod_sh;
  logic signed [AW-1:0] acc_q;

  // Product register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      prod_q <= a_i * b_i;
    end
  end

  // Floor shift by 16: drop the low fraction bits
  assign prod_sh = prod_q[PW-1:mmta_pkg::PROD_SHIFT];

  // Accumulator
  always_ff @(posedge clk_i) begin
    if (ctrl_i.init) begin
      acc_q <= ctrl_i.use_c ? AW'(c_i) : '0;
    end else if (ctrl_i.acc) begin
      acc_q <= acc_q + AW'(prod_sh);
    end
  end

  // Saturate to the element width
  always_comb begin
    sat_o    = 1'b0;
    result_o = acc_q[DATA_WIDTH-1:0];
    if (acc_q > HI) begin
      sat_o    = 1'b1;
      result_o = HI[DATA_WIDTH-1:0];
    end else if (acc_q < LO) begin
      sat_o    = 1'b1;
      result_o = LO[DATA_WIDTH-1:0];
    end
  end

endmodule

@@ tb/sv/matrix_multiply_transpose_accumulate_top_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for matrix_multiply_transpose_accumulate_top.
// Holds a fixed-point GEMM predictor, stimulus tasks and a result checker.
// Depends on mmta_pkg and the RTL top level only.
module matrix_multiply_transpose_accumulate_top_tb;

  localparam int DIM          = 16;
  localparam int CELLS        = DIM * DIM;
  localparam int WORD_TARGET  = 1950;
  localparam longint SAT_HI   = 64'sd2147483647;
  localparam longint SAT_LO   = -64'sd2147483648;
  localparam int MAX_REPORTS  = 40;

  // DUT ports
  logic                                clk_i;
  logic                                rst_ni;
  logic                                psel;
  logic                                penable;
  logic                                pwrite;
  logic [mmta_pkg::ADDR_W-1:0]         paddr;
  logic [31:0]                         pwdata;
  logic [31:0]                         prdata;
  logic                                pready;
  logic                                in_valid_i;
  logic                                in_stall_o;
  logic [2:0]                          operation_i;
  logic [3:0]                          row_i;
  logic [3:0]                          col_i;
  logic signed [mmta_pkg::VALUE_W-1:0] value_i;
  logic                                out_valid_o;
  logic                                out_stall_i;
  logic signed [mmta_pkg::VALUE_W-1:0] read_value_o;
  logic                                done_res_o;
  logic                                saturated_o;

  matrix_multiply_transpose_accumulate_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .row_i        (row_i),
    .col_i        (col_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_value_o (read_value_o),
    .done_res_o   (done_res_o),
    .saturated_o  (saturated_o)
  );

  // Expected result word
  typedef struct {
    logic signed [31:0] value;
    logic               done;
    logic               sat;
  } c_word_t;

  c_word_t expected_words[$];

  // Predictor state: stores, written masks, flag and register copies
  logic signed [31:0] a_mem [CELLS];
  logic signed [31:0] b_mem [CELLS];
  logic signed [31:0] c_mem [CELLS];
  bit                 a_set [CELLS];
  bit                 b_set [CELLS];
  bit                 c_set [CELLS];
  logic               sat_flag;
  logic               tr_a, tr_b, tr_c, accum_en;
  logic [4:0]         rows_cfg, links_cfg, cols_cfg;

  // Traffic shaping and bookkeeping
  int gap_mode;
  int stall_mode;
  int stall_phase = 0;
  int burst_left;
  int words_sent;
  int mult_count;
  int read_count;
  int sat_count;
  int setting_count;
  int fail_count;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("Timeout: %0d words still expected", expected_words.size());
    $display("Some tests failed");
    $finish;
  end

  // Receiver stall pattern
  always @(posedge clk_i) begin
    stall_phase <= stall_phase + 1;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= ((stall_phase % 7) < 3);
    endcase
  end

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_REPORTS) $display("%0t: MISMATCH %s", $realtime, msg);
    fail_count++;
  endtask

  // Compare each taken result word with the oldest expectation
  always @(posedge clk_i) begin : check_results
    c_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected result word value=%h done=%b sat=%b",
                                  read_value_o, done_res_o, saturated_o));
      end else begin
        want = expected_words.pop_front();
        if (read_value_o !== want.value)
          report_mismatch($sformatf("read_value got %h want %h", read_value_o, want.value));
        if (done_res_o !== want.done)
          report_mismatch($sformatf("done_res got %b want %b", done_res_o, want.done));
        if (saturated_o !== want.sat)
          report_mismatch($sformatf("saturated got %b want %b", saturated_o, want.sat));
      end
    end
  end

  function automatic int cell_at(input int r, input int c);
    return r * DIM + c;
  endfunction

  function automatic int clamp_dim(input logic [4:0] n);
    return (n > DIM) ? DIM : int'(n);
  endfunction

  // Mix of full-range, extreme and small Q16.16 values
  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(0, 4))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'hffff_ffff;
          default: return 32'h0001_0000;
        endcase
      end
      3, 4: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
    endcase
  endfunction

  // Count value: mostly small, sometimes zero, full size or above range
  function automatic logic [4:0] rand_count();
    case ($urandom_range(0, 19))
      0: return 5'd0;
      1: return 5'($urandom_range(DIM + 1, 31));
      2: return 5'(DIM);
      default: return 5'($urandom_range(1, 4));
    endcase
  endfunction

  // C = op(A) * op(B) (+ C), floor-shifted products, 32-bit saturation
  task automatic predict_product();
    int nr, nl, nc, ci;
    longint acc;
    nr = clamp_dim(rows_cfg);
    nl = clamp_dim(links_cfg);
    nc = clamp_dim(cols_cfg);
    sat_flag = 1'b0;
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        ci  = tr_c ? cell_at(j, i) : cell_at(i, j);
        acc = accum_en ? longint'(c_mem[ci]) : 64'sd0;
        for (int k = 0; k < nl; k++) begin
          acc += (longint'(a_mem[tr_a ? cell_at(k, i) : cell_at(i, k)]) *
                  longint'(b_mem[tr_b ? cell_at(j, k) : cell_at(k, j)]))
                 >>> mmta_pkg::PROD_SHIFT;
        end
        if (acc > SAT_HI) begin
          acc = SAT_HI;
          sat_flag = 1'b1;
        end
        if (acc < SAT_LO) begin
          acc = SAT_LO;
          sat_flag = 1'b1;
        end
        c_mem[ci] = 32'(acc);
        c_set[ci] = 1'b1;
      end
    end
  endtask

  // Update predictor for one accepted word and queue its result
  task automatic predict_word(input logic [2:0] op, input logic [3:0] r, input logic [3:0] c,
                              input logic [31:0] v);
    c_word_t res;
    int idx;
    idx = cell_at(r, c);
    case (op)
      mmta_pkg::OP_LOAD_A: begin
        a_mem[idx] = v;
        a_set[idx] = 1'b1;
      end
      mmta_pkg::OP_LOAD_B: begin
        b_mem[idx] = v;
        b_set[idx] = 1'b1;
      end
      mmta_pkg::OP_LOAD_C: begin
        c_mem[idx] = v;
        c_set[idx] = 1'b1;
      end
      mmta_pkg::OP_MULTIPLY: begin
        predict_product();
        res.value = '0;
        res.done  = 1'b1;
        res.sat   = sat_flag;
        expected_words.push_back(res);
        mult_count++;
        if (sat_flag) sat_count++;
      end
      mmta_pkg::OP_READ_C: begin
        res.value = c_mem[idx];
        res.done  = 1'b0;
        res.sat   = sat_flag;
        expected_words.push_back(res);
        read_count++;
      end
      default: ;
    endcase
  endtask

  // Send one word; bursts of random length separated by random gaps
  task automatic send_word(input logic [2:0] op, input logic [3:0] r, input logic [3:0] c,
                           input logic [31:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = (gap_mode == 0) ? 0 : $urandom_range(0, gap_mode * 4);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    operation_i <= op;
    row_i       <= r;
    col_i       <= c;
    value_i     <= v;
    do @(posedge clk_i); while (in_stall_o);
    predict_word(op, r, c, v);
    if (op <= mmta_pkg::OP_READ_C) words_sent++;
  endtask

  // Let every expected word arrive, then give the block time to settle
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // APB write: setup, access, then idle with psel low
  task automatic write_reg(input mmta_pkg::reg_e idx, input logic [4:0] val);
    logic [31:0] junk;
    junk = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    if (idx >= mmta_pkg::REG_ROW_COUNT) pwdata <= {junk[31:5], val};
    else pwdata <= {junk[31:1], val[0]};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      mmta_pkg::REG_TRANSPOSE_A:  tr_a      = val[0];
      mmta_pkg::REG_TRANSPOSE_B:  tr_b      = val[0];
      mmta_pkg::REG_TRANSPOSE_C:  tr_c      = val[0];
      mmta_pkg::REG_ACCUMULATE:   accum_en  = val[0];
      mmta_pkg::REG_ROW_COUNT:    rows_cfg  = val;
      mmta_pkg::REG_LINK_COUNT:   links_cfg = val;
      mmta_pkg::REG_COLUMN_COUNT: cols_cfg  = val;
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all(input logic ta, input logic tb, input logic tc, input logic ac,
                           input logic [4:0] nr, input logic [4:0] nl, input logic [4:0] nc);
    write_reg(mmta_pkg::REG_TRANSPOSE_A, {4'd0, ta});
    write_reg(mmta_pkg::REG_TRANSPOSE_B, {4'd0, tb});
    write_reg(mmta_pkg::REG_TRANSPOSE_C, {4'd0, tc});
    write_reg(mmta_pkg::REG_ACCUMULATE, {4'd0, ac});
    write_reg(mmta_pkg::REG_ROW_COUNT, nr);
    write_reg(mmta_pkg::REG_LINK_COUNT, nl);
    write_reg(mmta_pkg::REG_COLUMN_COUNT, nc);
    setting_count++;
  endtask

  // Load every operand entry the next multiply touches that was never written,
  // then issue the multiply with a random payload
  task automatic run_multiply();
    int nr, nl, nc, idx;
    nr = clamp_dim(rows_cfg);
    nl = clamp_dim(links_cfg);
    nc = clamp_dim(cols_cfg);
    for (int i = 0; i < nr; i++) begin
      for (int k = 0; k < nl; k++) begin
        idx = tr_a ? cell_at(k, i) : cell_at(i, k);
        if (!a_set[idx])
          send_word(mmta_pkg::OP_LOAD_A, 4'(idx / DIM), 4'(idx % DIM), rand_value());
      end
    end
    for (int k = 0; k < nl; k++) begin
      for (int j = 0; j < nc; j++) begin
        idx = tr_b ? cell_at(j, k) : cell_at(k, j);
        if (!b_set[idx])
          send_word(mmta_pkg::OP_LOAD_B, 4'(idx / DIM), 4'(idx % DIM), rand_value());
      end
    end
    if (accum_en) begin
      for (int i = 0; i < nr; i++) begin
        for (int j = 0; j < nc; j++) begin
          idx = tr_c ? cell_at(j, i) : cell_at(i, j);
          if (!c_set[idx])
            send_word(mmta_pkg::OP_LOAD_C, 4'(idx / DIM), 4'(idx % DIM), rand_value());
        end
      end
    end
    send_word(mmta_pkg::OP_MULTIPLY, 4'($urandom), 4'($urandom), $urandom);
  endtask

  // Read one C entry: mostly inside the last product, else any written entry
  task automatic read_some_c();
    int nr, nc, i, j, idx, tries;
    nr = clamp_dim(rows_cfg);
    nc = clamp_dim(cols_cfg);
    if (nr > 0 && nc > 0 && $urandom_range(0, 3) != 0) begin
      i = $urandom_range(0, nr - 1);
      j = $urandom_range(0, nc - 1);
      idx = tr_c ? cell_at(j, i) : cell_at(i, j);
    end else begin
      tries = 0;
      do begin
        idx = $urandom_range(0, CELLS - 1);
        tries++;
      end while (!c_set[idx] && tries < 64);
      if (!c_set[idx])
        send_word(mmta_pkg::OP_LOAD_C, 4'(idx / DIM), 4'(idx % DIM), rand_value());
    end
    send_word(mmta_pkg::OP_READ_C, 4'(idx / DIM), 4'(idx % DIM), $urandom);
  endtask

  // Extremes, floor rounding, saturation both ways, corner cells, unknown codes,
  // accumulation and a zero count
  task automatic test_directed();
    gap_mode   = 1;
    stall_mode = 1;
    send_word(mmta_pkg::OP_LOAD_A, 4'd0, 4'd0, 32'h7fff_ffff);
    send_word(mmta_pkg::OP_LOAD_B, 4'd0, 4'd0, 32'h7fff_ffff);
    send_word(mmta_pkg::OP_MULTIPLY, 4'd0, 4'd0, 32'd0);
    send_word(mmta_pkg::OP_READ_C, 4'd0, 4'd0, 32'd0);
    send_word(mmta_pkg::OP_LOAD_A, 4'd0, 4'd0, 32'h8000_0000);
    send_word(mmta_pkg::OP_MULTIPLY, 4'hf, 4'hf, 32'hffff_ffff);
    send_word(mmta_pkg::OP_READ_C, 4'd0, 4'd0, 32'd0);
    // tiny negative product rounds down to -1 and clears the flag
    send_word(mmta_pkg::OP_LOAD_A, 4'd0, 4'd0, 32'h0000_0001);
    send_word(mmta_pkg::OP_LOAD_B, 4'd0, 4'd0, 32'hffff_ffff);
    send_word(mmta_pkg::OP_MULTIPLY, 4'd0, 4'd0, 32'd0);
    send_word(mmta_pkg::OP_READ_C, 4'd0, 4'd0, 32'd0);
    // corner cells of C
    send_word(mmta_pkg::OP_LOAD_C, 4'hf, 4'hf, 32'h8000_0000);
    send_word(mmta_pkg::OP_LOAD_C, 4'hf, 4'h0, 32'h7fff_ffff);
    send_word(mmta_pkg::OP_READ_C, 4'hf, 4'hf, 32'd0);
    send_word(mmta_pkg::OP_READ_C, 4'hf, 4'h0, 32'hffff_ffff);
    // unknown codes are dropped
    send_word(3'(mmta_pkg::OP_READ_C) + 3'd1, 4'hf, 4'hf, 32'hffff_ffff);
    send_word(3'(mmta_pkg::OP_READ_C) + 3'd2, 4'h0, 4'h0, 32'h0000_0000);
    send_word(3'(mmta_pkg::OP_READ_C) + 3'd3, 4'h5, 4'ha, 32'h5555_aaaa);
    // 1.0 * 2.0 added to 1.0
    drain();
    write_reg(mmta_pkg::REG_ACCUMULATE, 5'd1);
    send_word(mmta_pkg::OP_LOAD_A, 4'd0, 4'd0, 32'h0001_0000);
    send_word(mmta_pkg::OP_LOAD_B, 4'd0, 4'd0, 32'h0002_0000);
    send_word(mmta_pkg::OP_LOAD_C, 4'd0, 4'd0, 32'h0001_0000);
    send_word(mmta_pkg::OP_MULTIPLY, 4'd0, 4'd0, 32'd0);
    send_word(mmta_pkg::OP_READ_C, 4'd0, 4'd0, 32'd0);
    // zero rows: nothing computed, flag cleared
    drain();
    write_reg(mmta_pkg::REG_ROW_COUNT, 5'd0);
    send_word(mmta_pkg::OP_MULTIPLY, 4'd0, 4'd0, 32'd0);
    send_word(mmta_pkg::OP_READ_C, 4'd0, 4'd0, 32'd0);
    drain();
  endtask

  // Full-size products, the second with every flag set and counts above range
  task automatic test_large_sizes();
    gap_mode   = 0;
    stall_mode = 0;
    write_all(1'b0, 1'b0, 1'b0, 1'b0, 5'(DIM), 5'(DIM), 5'(DIM));
    run_multiply();
    repeat (4) read_some_c();
    drain();
    gap_mode   = 2;
    stall_mode = 3;
    write_all(1'b1, 1'b1, 1'b1, 1'b1, 5'd31, 5'd17, 5'd20);
    run_multiply();
    repeat (4) read_some_c();
    drain();
  endtask

  // Random settings, scattered loads, multiplies (sometimes chained) and reads
  task automatic test_random_gemm();
    while (words_sent < WORD_TARGET) begin
      drain();
      gap_mode   = $urandom_range(0, 2);
      stall_mode = $urandom_range(0, 3);
      write_all(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                rand_count(), rand_count(), rand_count());
      repeat ($urandom_range(0, 6))
        send_word(mmta_pkg::op_e'($urandom_range(0, 2)), 4'($urandom), 4'($urandom),
                  rand_value());
      run_multiply();
      if ($urandom_range(0, 3) == 0) run_multiply();
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 9))
          0: send_word(3'(mmta_pkg::OP_READ_C) + 3'($urandom_range(1, 3)), 4'($urandom),
                       4'($urandom), $urandom);
          1: send_word(mmta_pkg::op_e'($urandom_range(0, 2)), 4'($urandom), 4'($urandom),
                       rand_value());
          default: read_some_c();
        endcase
      end
    end
  endtask

  initial begin
    rst_ni      <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_valid_i  <= 1'b0;
    operation_i <= mmta_pkg::OP_LOAD_A;
    row_i       <= '0;
    col_i       <= '0;
    value_i     <= '0;
    gap_mode = 0;
    stall_mode = 0;
    burst_left = 0;
    words_sent = 0;
    mult_count = 0;
    read_count = 0;
    sat_count = 0;
    setting_count = 0;
    fail_count = 0;
    // register reset values
    sat_flag  = 1'b0;
    tr_a      = 1'b0;
    tr_b      = 1'b0;
    tr_c      = 1'b0;
    accum_en  = 1'b0;
    rows_cfg  = 5'd1;
    links_cfg = 5'd1;
    cols_cfg  = 5'd1;
    for (int i = 0; i < CELLS; i++) begin
      a_set[i] = 1'b0;
      b_set[i] = 1'b0;
      c_set[i] = 1'b0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_large_sizes();
    test_random_gemm();

    drain();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d words: %0d multiplies (%0d saturating), %0d reads of C,",
             words_sent, mult_count, sat_count, read_count);
    $display("over %0d register settings; %0d mismatches", setting_count, fail_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/mmta_pkg.sv
rtl/core/mmta_ram.sv
rtl/core/mmta_mac.sv
rtl/core/matrix_multiply_transpose_accumulate_top.sv
tb/sv/matrix_multiply_transpose_accumulate_top_tb.sv
